// ===== design/stop_and_wait_arq_sender_macros.svh =====
// Assertion helpers for the ARQ sender.
`ifndef STOP_AND_WAIT_ARQ_SENDER_MACROS_SVH
`define STOP_AND_WAIT_ARQ_SENDER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, ignored while reset is high
`define SAW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, ignored while reset is high
`define SAW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SAW_ASSERT_IMP(label, clk, rst, ante, cons)
`define SAW_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/sawarq_pkg.sv =====
package sawarq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int QIDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int PAYLOAD_BYTES = 20;
   localparam int PAYLOAD_BITS = 8 * PAYLOAD_BYTES;
   // Signed sum of 20 bytes lies in -2560..2540
   localparam int SUM_W        = 13;
   localparam logic [15:0] TIMEOUT_RESET = 16'd22;
   localparam logic [31:0] ACK_VALUE     = 32'd1;

   typedef enum logic [1:0] {
      CMD_MESSAGE = 2'd0,
      CMD_PACKET  = 2'd1,
      CMD_EXPIRY  = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      OUT_SENT        = 3'd0,
      OUT_ACK_OK      = 3'd1,
      OUT_IGNORED     = 3'd2,
      OUT_DROP        = 3'd3,
      OUT_RESEND      = 3'd4,
      OUT_EXP_IGNORED = 3'd5
   } outcome_type;

   // One packet: sequence, payload and its signed byte sum
   typedef struct packed {
      logic [31:0]             seq;
      logic [63:0]             low;
      logic [63:0]             mid;
      logic [31:0]             high;
      logic signed [SUM_W-1:0] sum;
   } packet_type;

endpackage

// ===== design/stop_and_wait_arq_sender.sv =====
// Stop-and-wait ARQ sender.
// Input channel (req_*): one beat is a new message, an arriving packet or a
// timer expiry, selected by req_command. Result channel (rsp_*): exactly one
// beat per input beat, in order, telling whether a packet goes out, whether
// the retransmit timer starts or stops, and the outcome code.
// csr_write_enable/csr_write_data set the retransmit timeout (reset 22);
// write it only while no beat is in the block.
// A beat goes through the input register, then the protocol update into the
// result register. One beat per cycle while rsp_stall lets the result move;
// the sender state (in-flight packet and the 16-entry queue) is updated once
// per cycle in the second stage, when that stage advances.
// When rsp_stall is high the result register holds, the input register
// fills behind it and req_stall then rises; nothing is lost or repeated.
// Reset (synchronous) empties both stages and the queue, clears the in-flight
// flag and the sequence counter, and restores the timeout to 22. Queue
// storage is not cleared; only counted entries are ever read.
`include "stop_and_wait_arq_sender_macros.svh"

module stop_and_wait_arq_sender
   import sawarq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_payload_low,
   input  logic [63:0] req_payload_mid,
   input  logic [31:0] req_payload_high,
   input  logic [31:0] req_pkt_seq,
   input  logic signed [31:0] req_pkt_ack,
   input  logic signed [31:0] req_pkt_checksum,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_send_valid,
   output logic [31:0] rsp_send_seq,
   output logic        rsp_send_ack,
   output logic signed [31:0] rsp_send_checksum,
   output logic [63:0] rsp_send_payload_low,
   output logic [63:0] rsp_send_payload_mid,
   output logic [31:0] rsp_send_payload_high,
   output logic        rsp_start_timer,
   output logic [15:0] rsp_timer_duration,
   output logic        rsp_stop_timer,
   output logic [2:0]  rsp_outcome
);

   // Sum of all payload bytes, each taken as signed
   function automatic logic signed [SUM_W-1:0] byte_sum(input logic [PAYLOAD_BITS-1:0] p);
      logic signed [SUM_W-1:0] s;
      s = '0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         s = s + SUM_W'(signed'(p[8*i +: 8]));
      end
      return s;
   endfunction

   function automatic logic [QIDX_W-1:0] wrap_inc(input logic [QIDX_W-1:0] p);
      return (p == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Configuration
   logic [15:0] timeout_ff, timeout_in;

   // Input stage
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_command_ff, s1_command_in;
   packet_type  s1_pkt_ff, s1_pkt_in;
   logic [31:0] s1_ack_ff, s1_ack_in;
   logic [31:0] s1_csum_ff, s1_csum_in;

   // Sender state
   logic [31:0]       next_seq_ff, next_seq_in;
   logic              flight_valid_ff, flight_valid_in;
   packet_type        flight_ff, flight_in;
   packet_type        queue_mem_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] queue_head_ff, queue_head_in;
   logic [QIDX_W-1:0] queue_tail_ff, queue_tail_in;
   logic [QCNT_W-1:0] queue_count_ff, queue_count_in;
   logic              push;
   packet_type        push_entry;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        send_ff, send_in;
   logic        stop_ff, stop_in;
   outcome_type outcome_ff, outcome_in;
   packet_type  sent_ff, sent_in;
   logic [31:0] sent_csum_ff, sent_csum_in;
   logic [15:0] duration_ff, duration_in;

   logic advance;
   logic ack_ok;
   logic [31:0] rx_csum;

   // Handshake: stage 2 moves when the result register is free or drained
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;

   always_comb begin
      timeout_in = csr_write_enable ? csr_write_data : timeout_ff;
   end

   // Load the input register, with the byte sum of the arriving payload
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_command_in = s1_command_ff;
      s1_pkt_in     = s1_pkt_ff;
      s1_ack_in     = s1_ack_ff;
      s1_csum_in    = s1_csum_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         if (req_valid) begin
            s1_command_in  = req_command;
            s1_pkt_in.seq  = req_pkt_seq;
            s1_pkt_in.low  = req_payload_low;
            s1_pkt_in.mid  = req_payload_mid;
            s1_pkt_in.high = req_payload_high;
            s1_pkt_in.sum  = byte_sum({req_payload_high, req_payload_mid, req_payload_low});
            s1_ack_in      = $unsigned(req_pkt_ack);
            s1_csum_in     = $unsigned(req_pkt_checksum);
         end
      end
   end

   // Checksum the arriving packet would need to be accepted
   assign rx_csum = 32'(s1_pkt_ff.sum) + s1_pkt_ff.seq + s1_ack_ff;
   assign ack_ok  = flight_valid_ff && (s1_ack_ff == ACK_VALUE)
                    && (s1_pkt_ff.seq == flight_ff.seq) && (s1_csum_ff == rx_csum);

   // Protocol step on the beat in the input register
   always_comb begin
      next_seq_in     = next_seq_ff;
      flight_valid_in = flight_valid_ff;
      flight_in       = flight_ff;
      queue_head_in   = queue_head_ff;
      queue_tail_in   = queue_tail_ff;
      queue_count_in  = queue_count_ff;
      push            = 1'b0;
      push_entry      = s1_pkt_ff;
      push_entry.seq  = next_seq_ff;
      send_in         = 1'b0;
      stop_in         = 1'b0;
      outcome_in      = OUT_IGNORED;

      if (s1_valid_ff) begin
         case (s1_command_ff)
            CMD_MESSAGE: begin
               if (!flight_valid_ff) begin
                  flight_valid_in = 1'b1;
                  flight_in       = push_entry;
                  next_seq_in     = next_seq_ff + 32'd1;
                  send_in         = 1'b1;
                  outcome_in      = OUT_SENT;
               end else if (queue_count_ff == QCNT_W'(QUEUE_DEPTH)) begin
                  outcome_in = OUT_DROP;
               end else begin
                  push           = 1'b1;
                  queue_tail_in  = wrap_inc(queue_tail_ff);
                  queue_count_in = queue_count_ff + 1'b1;
                  next_seq_in    = next_seq_ff + 32'd1;
                  outcome_in     = OUT_SENT;
               end
            end
            CMD_PACKET: begin
               if (ack_ok) begin
                  stop_in         = 1'b1;
                  outcome_in      = OUT_ACK_OK;
                  flight_valid_in = 1'b0;
                  if (queue_count_ff != '0) begin
                     flight_valid_in = 1'b1;
                     flight_in       = queue_mem_ff[queue_head_ff];
                     queue_head_in   = wrap_inc(queue_head_ff);
                     queue_count_in  = queue_count_ff - 1'b1;
                     send_in         = 1'b1;
                  end
               end
            end
            CMD_EXPIRY: begin
               if (flight_valid_ff) begin
                  send_in    = 1'b1;
                  outcome_in = OUT_RESEND;
               end else begin
                  outcome_in = OUT_EXP_IGNORED;
               end
            end
            default: begin
               outcome_in = OUT_IGNORED;
            end
         endcase
      end
   end

   // Result register contents; zero fields when nothing is sent
   always_comb begin
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
      sent_in      = send_in ? flight_in : '0;
      sent_csum_in = send_in ? (32'(flight_in.sum) + flight_in.seq + ACK_VALUE) : 32'd0;
      duration_in  = send_in ? timeout_ff : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff      <= TIMEOUT_RESET;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         next_seq_ff     <= '0;
         flight_valid_ff <= 1'b0;
         queue_head_ff   <= '0;
         queue_tail_ff   <= '0;
         queue_count_ff  <= '0;
      end else begin
         timeout_ff   <= timeout_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            next_seq_ff     <= next_seq_in;
            flight_valid_ff <= flight_valid_in;
            queue_head_ff   <= queue_head_in;
            queue_tail_ff   <= queue_tail_in;
            queue_count_ff  <= queue_count_in;
         end
      end
      // Payload: no reset needed
      s1_command_ff <= s1_command_in;
      s1_pkt_ff     <= s1_pkt_in;
      s1_ack_ff     <= s1_ack_in;
      s1_csum_ff    <= s1_csum_in;
      if (advance) begin
         flight_ff    <= flight_in;
         send_ff      <= send_in;
         stop_ff      <= stop_in;
         outcome_ff   <= outcome_in;
         sent_ff      <= sent_in;
         sent_csum_ff <= sent_csum_in;
         duration_ff  <= duration_in;
         if (push && !reset) begin
            queue_mem_ff[queue_tail_ff] <= push_entry;
         end
      end
   end

   // Drive the result beat
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_send_valid        = send_ff;
   assign rsp_send_seq          = sent_ff.seq;
   assign rsp_send_ack          = send_ff;
   assign rsp_send_checksum     = signed'(sent_csum_ff);
   assign rsp_send_payload_low  = sent_ff.low;
   assign rsp_send_payload_mid  = sent_ff.mid;
   assign rsp_send_payload_high = sent_ff.high;
   assign rsp_start_timer       = send_ff;
   assign rsp_timer_duration    = duration_ff;
   assign rsp_stop_timer        = stop_ff;
   assign rsp_outcome           = outcome_ff;

   `SAW_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, queue_count_ff <= QCNT_W'(QUEUE_DEPTH))
   `SAW_ASSERT_IMP(a_queue_needs_flight, clock, reset, queue_count_ff != '0, flight_valid_ff)
   `SAW_ASSERT_IMP(a_stop_is_ack, clock, reset, rsp_valid_ff && stop_ff,
                   outcome_ff == OUT_ACK_OK)
   `SAW_ASSERT_NXT(a_drop_keeps_count, clock, reset,
                   advance && s1_valid_ff && (outcome_in == OUT_DROP),
                   queue_count_ff == QCNT_W'(QUEUE_DEPTH))

endmodule

// ===== tb/stop_and_wait_arq_sender_check.sv =====
package sawarq_tb_pkg;
   import sawarq_pkg::*;

   // Command code that the block decodes as nothing at all
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   // One beat on the input channel
   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] low;
      logic [63:0] mid;
      logic [31:0] high;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [31:0] csum;
   } beat_type;

   // Wrapping sum of the signed payload bytes plus sequence and ack field
   function automatic logic [31:0] frame_checksum(input logic [63:0] lo,
                                                   input logic [63:0] mid,
                                                   input logic [31:0] hi,
                                                   input logic [31:0] seq,
                                                   input logic [31:0] ack);
      logic [8*PAYLOAD_BYTES-1:0] octets;
      logic [31:0]                total;
      int                         i;
      octets = {hi, mid, lo};
      total  = seq + ack;
      for (i = 0; i < PAYLOAD_BYTES; i++) begin
         total = total + {{24{octets[8*i+7]}}, octets[8*i +: 8]};
      end
      return total;
   endfunction

endpackage

module stop_and_wait_arq_sender_check
   import sawarq_pkg::*;
   import sawarq_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_payload_low,
   input  logic [63:0] req_payload_mid,
   input  logic [31:0] req_payload_high,
   input  logic [31:0] req_pkt_seq,
   input  logic [31:0] req_pkt_ack,
   input  logic [31:0] req_pkt_checksum,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_send_valid,
   input  logic [31:0] rsp_send_seq,
   input  logic        rsp_send_ack,
   input  logic [31:0] rsp_send_checksum,
   input  logic [63:0] rsp_send_payload_low,
   input  logic [63:0] rsp_send_payload_mid,
   input  logic [31:0] rsp_send_payload_high,
   input  logic        rsp_start_timer,
   input  logic [15:0] rsp_timer_duration,
   input  logic        rsp_stop_timer,
   input  logic [2:0]  rsp_outcome,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] seq;
      logic [63:0] low;
      logic [63:0] mid;
      logic [31:0] high;
   } held_packet_type;

   typedef struct packed {
      logic        send_valid;
      logic [31:0] seq;
      logic        ack;
      logic [31:0] checksum;
      logic [63:0] low;
      logic [63:0] mid;
      logic [31:0] high;
      logic        start_timer;
      logic [15:0] duration;
      logic        stop_timer;
      logic [2:0]  outcome;
   } send_record_type;

   logic [15:0]     timeout_ticks;
   logic [31:0]     seq_counter;
   logic            in_flight;
   held_packet_type flight;
   held_packet_type backlog[$];
   send_record_type awaited_sends[$];
   send_record_type got;
   send_record_type want;
   int              fail_count = 0;
   string           diff;

   // Put the packet in flight on the network and restart the timer
   function automatic send_record_type with_flight_sent(input send_record_type r);
      r.send_valid  = 1'b1;
      r.seq         = flight.seq;
      r.ack         = 1'b1;
      r.checksum    = frame_checksum(flight.low, flight.mid, flight.high,
                                     flight.seq, ACK_VALUE);
      r.low         = flight.low;
      r.mid         = flight.mid;
      r.high        = flight.high;
      r.start_timer = 1'b1;
      r.duration    = timeout_ticks;
      return r;
   endfunction

   // Advance the sender by one beat and return the result it owes
   function automatic send_record_type advance_sender(input beat_type b);
      send_record_type r;
      r = '0;
      case (b.command)
         CMD_MESSAGE: begin
            if (!in_flight) begin
               flight      = '{seq: seq_counter, low: b.low, mid: b.mid, high: b.high};
               in_flight   = 1'b1;
               seq_counter = seq_counter + 32'd1;
               r           = with_flight_sent(r);
               r.outcome   = OUT_SENT;
            end else if (backlog.size() >= QUEUE_DEPTH) begin
               r.outcome = OUT_DROP;
            end else begin
               backlog.insert(backlog.size(),
                              held_packet_type'{seq: seq_counter, low: b.low,
                                                mid: b.mid, high: b.high});
               seq_counter = seq_counter + 32'd1;
               r.outcome   = OUT_SENT;
            end
         end
         CMD_PACKET: begin
            if (in_flight && b.ack == ACK_VALUE && b.seq == flight.seq &&
                b.csum == frame_checksum(b.low, b.mid, b.high, b.seq, b.ack)) begin
               in_flight    = 1'b0;
               r.stop_timer = 1'b1;
               // hand the oldest queued packet straight to the network
               if (backlog.size() > 0) begin
                  flight    = backlog.pop_front();
                  in_flight = 1'b1;
                  r         = with_flight_sent(r);
               end
               r.outcome = OUT_ACK_OK;
            end else begin
               r.outcome = OUT_IGNORED;
            end
         end
         CMD_EXPIRY: begin
            if (in_flight) begin
               r         = with_flight_sent(r);
               r.outcome = OUT_RESEND;
            end else begin
               r.outcome = OUT_EXP_IGNORED;
            end
         end
         default: r.outcome = OUT_IGNORED;
      endcase
      return r;
   endfunction

   function automatic string describe(input send_record_type r);
      return $sformatf({"send=%0b seq=%h ack=%0b csum=%h lo=%h mid=%h hi=%h ",
                        "start=%0b dur=%0d stop=%0b outcome=%0d"},
                       r.send_valid, r.seq, r.ack, r.checksum, r.low, r.mid, r.high,
                       r.start_timer, r.duration, r.stop_timer, r.outcome);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         timeout_ticks = TIMEOUT_RESET;
         seq_counter   = '0;
         in_flight     = 1'b0;
         flight        = '0;
         backlog.delete();
         awaited_sends.delete();
      end else begin
         // compare each result beat with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got.send_valid  = rsp_send_valid;
            got.seq         = rsp_send_seq;
            got.ack         = rsp_send_ack;
            got.checksum    = rsp_send_checksum;
            got.low         = rsp_send_payload_low;
            got.mid         = rsp_send_payload_mid;
            got.high        = rsp_send_payload_high;
            got.start_timer = rsp_start_timer;
            got.duration    = rsp_timer_duration;
            got.stop_timer  = rsp_stop_timer;
            got.outcome     = rsp_outcome;
            if (awaited_sends.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result beat with nothing awaited: %s", $time, describe(got));
               fail_count++;
            end else begin
               want = awaited_sends.pop_front();
               diff = "";
               if (got.send_valid !== want.send_valid) diff = {diff, " send_valid"};
               if (got.seq !== want.seq) diff = {diff, " send_seq"};
               if (got.ack !== want.ack) diff = {diff, " send_ack"};
               if (got.checksum !== want.checksum) diff = {diff, " send_checksum"};
               if (got.low !== want.low) diff = {diff, " payload_low"};
               if (got.mid !== want.mid) diff = {diff, " payload_mid"};
               if (got.high !== want.high) diff = {diff, " payload_high"};
               if (got.start_timer !== want.start_timer) diff = {diff, " start_timer"};
               if (got.duration !== want.duration) diff = {diff, " timer_duration"};
               if (got.stop_timer !== want.stop_timer) diff = {diff, " stop_timer"};
               if (got.outcome !== want.outcome) diff = {diff, " outcome"};
               if (diff != "") begin
                  if (fail_count < 10) begin
                     $display("%0t: mismatch on%s", $time, diff);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(got));
                  end
                  fail_count++;
               end
            end
         end
         if (csr_write_enable) timeout_ticks = csr_write_data;
         // predict the result of each accepted input beat
         if (req_valid && !req_stall) begin
            awaited_sends.insert(awaited_sends.size(),
                                 advance_sender('{command: req_command,
                                                  low: req_payload_low,
                                                  mid: req_payload_mid,
                                                  high: req_payload_high,
                                                  seq: req_pkt_seq,
                                                  ack: req_pkt_ack,
                                                  csum: req_pkt_checksum}));
         end
      end
      pending  <= awaited_sends.size();
      failures <= fail_count;
   end

endmodule

// ===== tb/stop_and_wait_arq_sender_test.sv =====
module stop_and_wait_arq_sender_test
   import sawarq_pkg::*;
   import sawarq_tb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_LENGTH = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = '0;
   logic [63:0] req_payload_low = '0;
   logic [63:0] req_payload_mid = '0;
   logic [31:0] req_payload_high = '0;
   logic [31:0] req_pkt_seq = '0;
   logic [31:0] req_pkt_ack = '0;
   logic [31:0] req_pkt_checksum = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_send_valid;
   logic [31:0] rsp_send_seq;
   logic        rsp_send_ack;
   logic [31:0] rsp_send_checksum;
   logic [63:0] rsp_send_payload_low;
   logic [63:0] rsp_send_payload_mid;
   logic [31:0] rsp_send_payload_high;
   logic        rsp_start_timer;
   logic [15:0] rsp_timer_duration;
   logic        rsp_stop_timer;
   logic [2:0]  rsp_outcome;

   int          failures;
   int          pending;
   int          cycle_count = 0;
   logic        calm = 1'b0;
   logic        hold_armed = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_cycles = 0;

   // Shadow of the link, enough to build acks that the block accepts
   int          unacked = 0;
   logic [31:0] oldest_seq = '0;
   int          n_messages = 0;
   int          n_dropped = 0;
   int          n_packets = 0;
   int          n_acked = 0;
   int          n_expiries = 0;
   int          n_reserved = 0;

   stop_and_wait_arq_sender uut (.*);

   stop_and_wait_arq_sender_check watch (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timed out after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("stop_and_wait_arq_sender_test: FAIL");
      $finish;
   end

   // Receiver: stall at random, or hold off for a counted stretch once armed
   always @(posedge clock) begin
      if (hold_armed && !hold_done) begin
         hold_done   <= 1'b1;
         hold_cycles <= HOLD_LENGTH - 1;
         rsp_stall   <= 1'b1;
      end else if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 24);
      end
   end

   function automatic beat_type fresh_beat(input logic [1:0] cmd);
      beat_type b;
      b.command = cmd;
      b.low     = {$urandom, $urandom};
      b.mid     = {$urandom, $urandom};
      b.high    = $urandom;
      b.seq     = $urandom;
      b.ack     = $urandom;
      b.csum    = $urandom;
      return b;
   endfunction

   function automatic beat_type with_checksum(input beat_type b);
      b.csum = frame_checksum(b.low, b.mid, b.high, b.seq, b.ack);
      return b;
   endfunction

   // Acknowledgement for the packet currently in flight
   function automatic beat_type valid_ack();
      beat_type b;
      b     = fresh_beat(CMD_PACKET);
      b.seq = oldest_seq;
      b.ack = ACK_VALUE;
      return with_checksum(b);
   endfunction

   // Mostly well-formed traffic, the rest broken acks and noise
   function automatic beat_type random_beat();
      beat_type b;
      int       pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         b = fresh_beat(CMD_MESSAGE);
      end else if (pick < 70) begin
         b = valid_ack();
      end else if (pick < 80) begin
         b = fresh_beat(CMD_EXPIRY);
      end else if (pick < 95) begin
         b = valid_ack();
         case ($urandom_range(0, 3))
            0: begin
               b.ack = $urandom;
               if (b.ack == ACK_VALUE) b.ack = '0;
               b = with_checksum(b);
            end
            1: begin
               // stale ack for the previous packet
               b.seq = b.seq - 32'd1;
               b = with_checksum(b);
            end
            2: b.csum = b.csum ^ (32'd1 << $urandom_range(0, 31));
            default: b = fresh_beat(CMD_PACKET);
         endcase
      end else begin
         b = fresh_beat(CMD_RESERVED);
      end
      return b;
   endfunction

   // Track what the block has accepted so that later acks line up
   task automatic note_beat(input beat_type b);
      case (b.command)
         CMD_MESSAGE: begin
            n_messages++;
            if (unacked > QUEUE_DEPTH) n_dropped++;
            else unacked++;
         end
         CMD_PACKET: begin
            n_packets++;
            if (unacked > 0 && b.ack == ACK_VALUE && b.seq == oldest_seq &&
                b.csum == frame_checksum(b.low, b.mid, b.high, b.seq, b.ack)) begin
               oldest_seq = oldest_seq + 32'd1;
               unacked--;
               n_acked++;
            end
         end
         CMD_EXPIRY: n_expiries++;
         default: n_reserved++;
      endcase
   endtask

   // Offer one beat, after an optional idle gap, and hold it until taken
   task automatic drive_beat(input beat_type b);
      while (!calm && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= b.command;
      req_payload_low  <= b.low;
      req_payload_mid  <= b.mid;
      req_payload_high <= b.high;
      req_pkt_seq      <= b.seq;
      req_pkt_ack      <= b.ack;
      req_pkt_checksum <= b.csum;
      do @(posedge clock); while (req_stall);
      note_beat(b);
   endtask

   // Stop offering and wait until every awaited result has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [15:0] ticks);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= ticks;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      beat_type    b;
      int          phase;
      logic [15:0] ticks;
      logic [15:0] rand_ticks;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // idle link: expiry, ack and reserved command all ignored
      drive_beat(fresh_beat(CMD_EXPIRY));
      drive_beat(valid_ack());
      b = '1;
      drive_beat(b);
      // first message goes out at once, then is resent
      b = fresh_beat(CMD_MESSAGE);
      b.low = '0;
      b.mid = '0;
      b.high = '0;
      drive_beat(b);
      drive_beat(fresh_beat(CMD_EXPIRY));
      // broken acks: bad ack field, wrong sequence, corrupt checksum
      b = valid_ack();
      b.ack = '0;
      drive_beat(with_checksum(b));
      b.ack = '1;
      drive_beat(with_checksum(b));
      b.ack = 32'h8000_0000;
      drive_beat(with_checksum(b));
      b = valid_ack();
      b.seq = b.seq + 32'd1;
      drive_beat(with_checksum(b));
      b = valid_ack();
      b.csum = b.csum ^ 32'h8000_0000;
      drive_beat(b);
      drive_beat(valid_ack());
      // extreme payload bytes, queued behind the first
      b = fresh_beat(CMD_MESSAGE);
      b.low = '1;
      b.mid = '1;
      b.high = '1;
      drive_beat(b);
      b.low = {8{8'h80}};
      b.mid = {8{8'h80}};
      b.high = {4{8'h80}};
      drive_beat(b);
      b.low = {8{8'h7F}};
      b.mid = {8{8'h7F}};
      b.high = {4{8'h7F}};
      drive_beat(b);
      drive_beat(fresh_beat(CMD_MESSAGE));
      drive_beat(valid_ack());
      drive_beat(fresh_beat(CMD_EXPIRY));
      b = valid_ack();
      b.seq = '1;
      drive_beat(with_checksum(b));
      repeat (3) drive_beat(valid_ack());
      drive_beat(fresh_beat(CMD_EXPIRY));

      // random phases, each under its own timeout setting
      rand_ticks = 16'($urandom_range(2, 65534));
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: ticks = 16'hFFFF;
            1: ticks = 16'd1;
            2: ticks = 16'd0;
            3: ticks = rand_ticks;
            default: ticks = TIMEOUT_RESET;
         endcase
         set_timeout(ticks);
         calm <= (phase == 2);
         if (phase == 1) hold_armed <= 1'b1;
         // flood the queue so that messages get dropped
         if (phase == 3) repeat (20) drive_beat(fresh_beat(CMD_MESSAGE));
         repeat (100) drive_beat(random_beat());
      end
      calm <= 1'b0;

      drain_results();
      repeat (8) @(posedge clock);
      $display("covered %0d messages (%0d dropped on a full queue), %0d packets (%0d acked),",
               n_messages, n_dropped, n_packets, n_acked);
      $display("   %0d expiries, %0d reserved commands; timeouts 22, 65535, 1, 0, %0d, 22",
               n_expiries, n_reserved, rand_ticks);
      if (failures == 0) $display("stop_and_wait_arq_sender_test: PASS");
      else $display("stop_and_wait_arq_sender_test: FAIL");
      $finish;
   end

endmodule
